// ----- hw/rtl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and mixing functions for the hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned DIGEST_WDS  = 8;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] HASH_IV [DIGEST_WDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    // sequencer controls to the datapath
    typedef struct packed {
        logic       byte_shift;
        logic [7:0] byte_data;
        logic       ld_work;
        logic       round_en;
        logic       fin_add;
        logic       hash_init;
        logic [5:0] rnd;
    } ctl_t;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- hw/rtl/sha256_sched.sv -----
// ----------------------------------------------------------------------------
// SHA-256 block buffer and message schedule
// 512-bit shift line: bytes shift in while filling, schedule words during rounds.
// ----------------------------------------------------------------------------
module sha256_sched
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  ctl_t        ctl,
    output logic [31:0] w_t
);

    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [31:0]  w_new;

    // window holds W[t..t+15], oldest word in the top bits
    assign w_t   = blk_reg[511:480];
    assign w_new = ssig1(blk_reg[63:32]) + blk_reg[223:192]
                 + ssig0(blk_reg[479:448]) + blk_reg[511:480];

    always_comb begin
        blk_next = blk_reg;
        if (ctl.byte_shift) begin
            blk_next = {blk_reg[503:0], ctl.byte_data};
        end else if (ctl.round_en) begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

endmodule

// ----- hw/rtl/sha256_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables, one compression round per cycle, and the hash state.
// ----------------------------------------------------------------------------
module sha256_round
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ctl_t        ctl,
    input  logic [31:0] w_t,
    output logic [31:0] hash_words [DIGEST_WDS]
);

    logic [31:0] work_reg [DIGEST_WDS];
    logic [31:0] work_next [DIGEST_WDS];
    logic [31:0] hash_reg [DIGEST_WDS];
    logic [31:0] hash_next [DIGEST_WDS];
    logic [31:0] t1;
    logic [31:0] t2;

    assign hash_words = hash_reg;

    assign t1 = work_reg[7] + bsig1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[ctl.rnd] + w_t;
    assign t2 = bsig0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    always_comb begin
        work_next = work_reg;
        if (ctl.ld_work) begin
            work_next = hash_reg;
        end else if (ctl.round_en) begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    always_comb begin
        hash_next = hash_reg;
        if (ctl.hash_init) begin
            hash_next = HASH_IV;
        end else if (ctl.fin_add) begin
            for (int i = 0; i < DIGEST_WDS; i++) begin
                hash_next[i] = hash_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (!aresetn) begin
            hash_reg <= HASH_IV;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ----- hw/rtl/sha256_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-256 sequencer
// Byte intake, padding, round counting and digest readout.
// ----------------------------------------------------------------------------
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_byte,
    input  logic       s_bvalid,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [2:0] out_idx,
    output ctl_t       ctl
);

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] cnt_reg, cnt_next;      // message length in bytes
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        pad_reg, pad_next;      // message ended, padding under way
    logic        sent80_reg, sent80_next;
    logic        lenok_reg, lenok_next;  // current block takes the length field
    logic        done_reg, done_next;    // last compression of the message running

    logic        in_acc;
    logic        out_acc;
    logic [63:0] bits_w;
    logic [5:0]  len_sel;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    assign in_acc  = s_tvalid && (state_reg == ST_IDLE);
    assign out_acc = m_tready && (state_reg == ST_OUT);
    assign out_idx = oidx_reg;

    // big-endian length: byte k of the field is bits[63-8k -: 8]
    assign bits_w   = {cnt_reg, 3'b000};
    assign len_sel  = {~fill_reg[2:0], 3'b000};
    assign len_byte = bits_w[len_sel +: 8];

    always_comb begin
        if (!sent80_reg) begin
            pad_byte = PAD_MARK;
        end else if (lenok_reg && (fill_reg >= 6'd56)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_bvalid && (fill_reg == 6'd63)) begin
                        state_next = ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (done_reg) begin
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (fill_reg == 6'd63) begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT: begin
                if (out_acc && (oidx_reg == 3'd7)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl          = '0;
        ctl.rnd      = rnd_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                ctl.byte_shift = in_acc && s_bvalid;
                ctl.byte_data  = s_byte;
                ctl.ld_work    = in_acc && s_bvalid && (fill_reg == 6'd63);
            end
            ST_ROUND: begin
                ctl.round_en = 1'b1;
            end
            ST_FINAL: begin
                ctl.fin_add = 1'b1;
            end
            ST_PAD: begin
                ctl.byte_shift = 1'b1;
                ctl.byte_data  = pad_byte;
                ctl.ld_work    = (fill_reg == 6'd63);
            end
            ST_OUT: begin
                m_tvalid      = 1'b1;
                ctl.hash_init = out_acc && (oidx_reg == 3'd7);
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    // counters and padding flags
    always_comb begin
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        rnd_next    = ctl.round_en ? rnd_reg + 6'd1 : 6'd0;
        oidx_next   = out_acc ? oidx_reg + 3'd1 : oidx_reg;
        pad_next    = pad_reg | (in_acc && s_tlast);
        sent80_next = sent80_reg;
        lenok_next  = lenok_reg;
        done_next   = done_reg;
        if (ctl.byte_shift) begin
            fill_next = fill_reg + 6'd1;
        end
        if (in_acc && s_bvalid) begin
            cnt_next = cnt_reg + 61'd1;
        end
        if (state_reg == ST_PAD) begin
            sent80_next = 1'b1;
            if (!sent80_reg && (fill_reg <= 6'd55)) begin
                lenok_next = 1'b1;
            end
            if (fill_reg == 6'd63) begin
                lenok_next = 1'b1;
                done_next  = lenok_reg;
            end
        end
        if (ctl.hash_init) begin
            cnt_next    = '0;
            pad_next    = 1'b0;
            sent80_next = 1'b0;
            lenok_next  = 1'b0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            cnt_reg    <= '0;
            rnd_reg    <= '0;
            oidx_reg   <= '0;
            pad_reg    <= 1'b0;
            sent80_reg <= 1'b0;
            lenok_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            rnd_reg    <= rnd_next;
            oidx_reg   <= oidx_next;
            pad_reg    <= pad_next;
            sent80_reg <= sent80_next;
            lenok_reg  <= lenok_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream with SHA-256 and emits the eight digest words.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Request carries
// -------   ---  ------------------------------------------------------------
// s_*       in   one message byte (tdata), byte present flag (tuser), end (tlast)
// m_*       out  one digest word with its index (tdata), final word (tlast)
//
// Timing: bytes are taken one a cycle while s_tready is high; the 64th byte of a
// block starts a compression: 64 rounds through the single round unit, then the hash update.
// After a request with tlast, padding shifts in 9 to 72 bytes, one a cycle while no
// compression runs, with one or two compressions, then eight result requests follow.
// s_tready is high only while the sequencer waits for bytes; a stalled
// m_tready simply holds the current digest word.
// Reset (aresetn low, synchronous) returns to the initial hash values with an
// empty message.
//
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    ctl_t        ctl;
    logic [31:0] w_t;
    logic [31:0] hash_words [DIGEST_WDS];
    logic [2:0]  out_idx;

    sha256_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_bvalid (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_idx  (out_idx),
        .ctl      (ctl)
    );

    // block buffer doubles as the rolling message schedule
    sha256_sched u_sched (
        .aclk (aclk),
        .ctl  (ctl),
        .w_t  (w_t)
    );

    sha256_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .w_t        (w_t),
        .hash_words (hash_words)
    );

    // digest words come straight from the hash registers, index from the sequencer
    assign m_tdata = {5'b00000, out_idx, hash_words[out_idx]};
    assign m_tlast = (out_idx == 3'd7);

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams byte requests into the hasher, predicts each digest in a
// scoreboard and compares every result word field by field. The run goes
// through three idle patterns plus a long output stall.
// ----------------------------------------------------------------------------
module tb
    import sha256_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 300;   // > worst pad + two compressions + output
    localparam int unsigned HOLD_CYCLES  = 400;   // long m_tready stall
    localparam int unsigned PHASE_ITEMS  = 78;    // random requests per phase
    localparam int unsigned EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        fin;
    } digest_word_t;

    // Scoreboard: software SHA-256 fed one request at a time.
    class digest_predictor;
        logic [7:0]   msg_block [BLOCK_BYTES];
        int unsigned  fill;
        logic [63:0]  bit_count;
        logic [31:0]  hash [DIGEST_WDS];
        logic [31:0]  sched [16];
        digest_word_t words_due [$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
            foreach (sched[i]) sched[i] = '0;
            restart();
        endfunction

        function void restart();
            fill      = 0;
            bit_count = '0;
            foreach (hash[i]) hash[i] = HASH_IV[i];
        endfunction

        function logic [31:0] rot_right(logic [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] v [8];
            logic [31:0] w, t1, t2, a2, a15;
            for (int i = 0; i < 8; i++) v[i] = hash[i];
            for (int i = 0; i < ROUNDS; i++) begin
                if (i < 16) begin
                    w = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
                end else begin
                    a2  = sched[(i - 2) & 15];
                    a15 = sched[(i - 15) & 15];
                    w = (rot_right(a2, 17) ^ rot_right(a2, 19) ^ (a2 >> 10))
                        + sched[(i - 7) & 15]
                        + (rot_right(a15, 7) ^ rot_right(a15, 18) ^ (a15 >> 3))
                        + sched[i & 15];
                end
                sched[i & 15] = w;
                t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w;
                t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash[i] = hash[i] + v[i];
        endfunction

        // One accepted input request.
        function void take_request(logic [7:0] data, logic has_byte, logic is_last);
            int unsigned  pos;
            digest_word_t dw;
            if (has_byte) begin
                msg_block[fill] = data;
                bit_count = bit_count + 64'd8;
                fill++;
                if (fill == BLOCK_BYTES) begin
                    compress();
                    fill = 0;
                end
            end
            if (!is_last) return;
            pos = fill;
            msg_block[pos] = PAD_MARK;
            pos++;
            // no room for the length: extra block first
            if (pos > 56) begin
                while (pos < 64) begin
                    msg_block[pos] = '0;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56) begin
                msg_block[pos] = '0;
                pos++;
            end
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_count[63-8*i -: 8];
            compress();
            for (int i = 0; i < DIGEST_WDS; i++) begin
                dw.word  = hash[i];
                dw.index = 3'(i);
                dw.fin   = (i == DIGEST_WDS - 1);
                words_due.push_back(dw);
            end
            restart();
        endfunction

        // One accepted result request.
        function void check_word(logic [39:0] data, logic tl);
            digest_word_t dw;
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected digest word %h idx %0d last %b",
                             data[31:0], data[34:32], tl);
                return;
            end
            dw = words_due.pop_front();
            if (data[31:0] !== dw.word || data[34:32] !== dw.index || tl !== dw.fin
                    || data[39:35] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: mismatch exp %h idx %0d last %b, got %h idx %0d last %b pad %h",
                             dw.word, dw.index, dw.fin, data[31:0], data[34:32], tl,
                             data[39:35]);
            end
        endfunction

        function int unsigned pending();
            return words_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] data_byte
    logic        s_tuser  = 1'b0;  // [0] byte_valid
    logic        s_tlast  = 1'b0;  // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;          // last_word

    digest_predictor predictor;
    int unsigned     tx_idle_pct   = 0;
    int unsigned     rx_idle_pct   = 0;
    int unsigned     hold_requests = 0;
    int unsigned     holds_served  = 0;
    int unsigned     hold_left     = 0;
    int unsigned     items_sent    = 0;
    int unsigned     cycles        = 0;

    sha256_stream_hasher DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Handshake monitors; values read here are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predictor.take_request(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) predictor.check_word(m_tdata, m_tlast);
        end
    end

    // Receiver: random backpressure, plus a long hold when one is asked for.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_item(logic [7:0] data, logic has_byte, logic is_last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Message of len bytes, with scattered empty requests; it ends either
    // with last on the final byte or with a separate empty last request.
    task automatic send_message(int unsigned len, int unsigned noise_pct);
        bit tail_empty;
        tail_empty = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (i == len - 1) && !tail_empty);
        end
        if (tail_empty) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // one edge first so the monitor has logged the request just accepted
    task automatic wait_drained();
        @(posedge aclk);
        while (predictor.pending() != 0) @(posedge aclk);
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return EDGE_LENS[$urandom_range(0, 7)];
        if (r < 15) return 0;
        return $urandom_range(1, 12);
    endfunction

    initial begin
        predictor = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message, empty requests that are not last,
        // single extreme bytes, byte with last vs empty last
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin tx_idle_pct = 27; rx_idle_pct = 64; end
                1: begin tx_idle_pct = 64; rx_idle_pct = 27; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            // open each phase on a padding boundary length
            case (p)
                0: send_message($urandom_range(55, 56), 5);
                1: send_message($urandom_range(63, 64), 5);
                default: send_message(EDGE_LENS[$urandom_range(0, 7)], 5);
            endcase
            // long output stall while requests keep coming
            if (p == 0) hold_requests++;
            while (items_sent < 13 + PHASE_ITEMS * (p + 1)) send_message(pick_length(), 10);
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
